### rtl/core/lzrms_pkg.sv
// Shared types, constants and helper functions for the longest-zero-run matrix scanner.
package lzrms_pkg;

	localparam int RUN_W = 8;
	localparam logic [RUN_W-1:0] RUN_LIMIT = 8'd255;
	localparam int CELL_W = 32;
	localparam int SIZE_W = 8;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd128;

	// Direction slots in the running-maximum array.
	localparam int DIR_ROW = 0;
	localparam int DIR_COL = 1;
	localparam int DIR_DIAG = 2;
	localparam int DIR_ANTI = 3;
	localparam int NUM_DIRS = 4;

	typedef logic [RUN_W-1:0] run_t;

	typedef struct packed {
		logic first_row;
		logic first_col;
		logic last_col;
		logic last_row;
	} pos_flags_t;

	typedef struct packed {
		run_t row_run;
		run_t col_run;
		run_t diag_run;
		run_t anti_diag_run;
		run_t longest_run;
	} result_t;

	// A zero cell extends the run ending at its predecessor, saturating at the limit.
	function automatic run_t extend_run(input logic is_zero, input run_t prev);
		run_t r;
		if (!is_zero) begin
			r = '0;
		end else if (prev == RUN_LIMIT) begin
			r = RUN_LIMIT;
		end else begin
			r = prev + run_t'(1);
		end
		return r;
	endfunction

	function automatic run_t max_run(input run_t a, input run_t b);
		return (a > b) ? a : b;
	endfunction

endpackage

### rtl/core/lzrms_ifs.sv
// Valid/ready channel interfaces for cells, results and the size register.
interface lzrms_cell_if import lzrms_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [CELL_W-1:0] cell_value;

	modport source (output valid, output cell_value, input ready);
	modport sink (input valid, input cell_value, output ready);
endinterface

interface lzrms_result_if import lzrms_pkg::*; ();
	logic valid;
	logic ready;
	logic [RUN_W-1:0] row_run;
	logic [RUN_W-1:0] col_run;
	logic [RUN_W-1:0] diag_run;
	logic [RUN_W-1:0] anti_diag_run;
	logic [RUN_W-1:0] longest_run;

	modport source (output valid, output row_run, output col_run, output diag_run,
		output anti_diag_run, output longest_run, input ready);
	modport sink (input valid, input row_run, input col_run, input diag_run,
		input anti_diag_run, input longest_run, output ready);
endinterface

interface lzrms_cfg_if import lzrms_pkg::*; ();
	logic valid;
	logic ready;
	logic [SIZE_W-1:0] matrix_size;

	modport source (output valid, output matrix_size, input ready);
	modport sink (input valid, input matrix_size, output ready);
endinterface

### rtl/core/lzrms_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lzrms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

### rtl/core/lzrms_pos.sv
// Raster position counters, edge flags and line-store read addresses.
module lzrms_pos import lzrms_pkg::*; #(
	parameter int MAX_SIDE = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [SIZE_W-1:0]           matrix_size,
	input  logic                        accept,
	output logic [$clog2(MAX_SIDE)-1:0] col,
	output logic [$clog2(MAX_SIDE)-1:0] anti_addr,
	output pos_flags_t                  flags
);
	localparam int IW = $clog2(MAX_SIDE);
	localparam int NW = $clog2(MAX_SIDE + 1);
	localparam int CW = ((NW > SIZE_W) ? NW : SIZE_W) + 1;

	logic [IW-1:0] row_q;
	logic [IW-1:0] col_q;
	logic [CW-1:0] size_w;
	logic [CW-1:0] side;
	logic [CW-1:0] col_next;
	logic [CW-1:0] row_next;

	always_comb begin
		size_w = CW'(matrix_size);
		if (size_w == '0) begin
			side = CW'(1);
		end else if (size_w > CW'(MAX_SIDE)) begin
			side = CW'(MAX_SIDE);
		end else begin
			side = size_w;
		end
		col_next = CW'(col_q) + CW'(1);
		row_next = CW'(row_q) + CW'(1);
		flags.first_row = (row_q == '0);
		flags.first_col = (col_q == '0);
		flags.last_col = (col_next >= side) || (col_next >= CW'(MAX_SIDE));
		flags.last_row = (row_next >= side);
		col = col_q;
		// The right neighbor does not exist on the last column; its read is masked later.
		anti_addr = flags.last_col ? col_q : col_next[IW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (flags.last_col) begin
				col_q <= '0;
				row_q <= flags.last_row ? '0 : row_next[IW-1:0];
			end else begin
				col_q <= col_next[IW-1:0];
			end
		end
	end
endmodule

### rtl/core/lzrms_core.sv
// Cell stage: line stores, run updates, running maxima and the result register.
module lzrms_core import lzrms_pkg::*; #(
	parameter int MAX_SIDE = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic                        cell_zero,
	input  logic [$clog2(MAX_SIDE)-1:0] col,
	input  logic [$clog2(MAX_SIDE)-1:0] anti_addr,
	input  pos_flags_t                  flags,
	output logic                        in_ready,
	output logic                        out_valid,
	input  logic                        out_ready,
	output result_t                     result
);
	localparam int IW = $clog2(MAX_SIDE);

	logic          valid_s1;
	logic          zero_s1;
	logic [IW-1:0] col_s1;
	pos_flags_t    flags_s1;
	logic          byp_v_s1;
	logic          byp_d_s1;
	logic          byp_a_s1;
	run_t          byp_v_data_s1;
	run_t          byp_d_data_s1;
	run_t          byp_a_data_s1;

	run_t horiz_q;
	run_t held_diag_q;
	run_t best_q [NUM_DIRS];
	logic out_valid_q;
	result_t result_q;

	run_t vert_rd;
	run_t diag_rd;
	run_t anti_rd;
	run_t above_v;
	run_t above_d;
	run_t above_a;
	run_t run_h;
	run_t run_v;
	run_t run_d;
	run_t run_a;
	run_t best_next [NUM_DIRS];
	run_t top_ab;
	run_t top_cd;
	logic matrix_end;
	logic commit;

	assign matrix_end = flags_s1.last_col && flags_s1.last_row;
	assign commit = valid_s1 && (!matrix_end || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || commit;

	lzrms_ram #(.WIDTH(RUN_W), .DEPTH(MAX_SIDE)) u_vert_ram (
		.clk(clk), .wr_en(commit), .wr_addr(col_s1), .wr_data(run_v),
		.rd_en(accept), .rd_addr(col), .rd_data(vert_rd)
	);

	lzrms_ram #(.WIDTH(RUN_W), .DEPTH(MAX_SIDE)) u_diag_ram (
		.clk(clk), .wr_en(commit), .wr_addr(col_s1), .wr_data(run_d),
		.rd_en(accept), .rd_addr(col), .rd_data(diag_rd)
	);

	lzrms_ram #(.WIDTH(RUN_W), .DEPTH(MAX_SIDE)) u_anti_ram (
		.clk(clk), .wr_en(commit), .wr_addr(col_s1), .wr_data(run_a),
		.rd_en(accept), .rd_addr(anti_addr), .rd_data(anti_rd)
	);

	always_comb begin
		// A read issued while the previous cell wrote the same entry takes the new value.
		above_v = byp_v_s1 ? byp_v_data_s1 : vert_rd;
		above_d = byp_d_s1 ? byp_d_data_s1 : diag_rd;
		above_a = byp_a_s1 ? byp_a_data_s1 : anti_rd;

		run_h = extend_run(zero_s1, flags_s1.first_col ? '0 : horiz_q);
		run_v = extend_run(zero_s1, flags_s1.first_row ? '0 : above_v);
		run_d = extend_run(zero_s1,
			(flags_s1.first_row || flags_s1.first_col) ? '0 : held_diag_q);
		run_a = extend_run(zero_s1,
			(flags_s1.first_row || flags_s1.last_col) ? '0 : above_a);

		best_next[DIR_ROW] = max_run(best_q[DIR_ROW], run_h);
		best_next[DIR_COL] = max_run(best_q[DIR_COL], run_v);
		best_next[DIR_DIAG] = max_run(best_q[DIR_DIAG], run_d);
		best_next[DIR_ANTI] = max_run(best_q[DIR_ANTI], run_a);
		top_ab = max_run(best_next[DIR_ROW], best_next[DIR_COL]);
		top_cd = max_run(best_next[DIR_DIAG], best_next[DIR_ANTI]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			zero_s1 <= cell_zero;
			col_s1 <= col;
			flags_s1 <= flags;
			byp_v_s1 <= commit && (col_s1 == col);
			byp_d_s1 <= commit && (col_s1 == col);
			byp_a_s1 <= commit && (col_s1 == anti_addr);
			byp_v_data_s1 <= run_v;
			byp_d_data_s1 <= run_d;
			byp_a_data_s1 <= run_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			horiz_q <= '0;
			held_diag_q <= '0;
			for (int k = 0; k < NUM_DIRS; k++) begin
				best_q[k] <= '0;
			end
		end else if (commit) begin
			if (matrix_end) begin
				horiz_q <= '0;
				held_diag_q <= '0;
				for (int k = 0; k < NUM_DIRS; k++) begin
					best_q[k] <= '0;
				end
			end else begin
				horiz_q <= run_h;
				held_diag_q <= flags_s1.first_row ? '0 : above_d;
				for (int k = 0; k < NUM_DIRS; k++) begin
					best_q[k] <= best_next[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit && matrix_end) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && matrix_end) begin
			result_q.row_run <= best_next[DIR_ROW];
			result_q.col_run <= best_next[DIR_COL];
			result_q.diag_run <= best_next[DIR_DIAG];
			result_q.anti_diag_run <= best_next[DIR_ANTI];
			result_q.longest_run <= max_run(top_ab, top_cd);
		end
	end

	assign out_valid = out_valid_q;
	assign result = result_q;
endmodule

### rtl/core/longest_zero_run_matrix_scan_top.sv
// Top level of the longest-zero-run matrix scanner.
//
//   Channel  Dir  Payload                                        Transfer when
//   cells    in   cell_value (signed 32)                         valid && ready
//   result   out  row_run col_run diag_run anti_diag_run         valid && ready
//                 longest_run (8 bits each)
//   cfg      in   matrix_size (8)                                valid && ready
//
// One cell is taken per clock unless the channel stalls; its line-store reads are issued
// as it transfers. It enters the cell stage with its read data, and all runs are updated
// when that stage commits it; for a last cell the result register loads at that commit.
// Reset is asynchronous and active low; it sets the side to 128 and clears held runs and maxima.
// The cells channel stalls only while a finished result waits and the next last cell
// is ready to produce another one; there is no clearing pass after reset.
module longest_zero_run_matrix_scan_top import lzrms_pkg::*; #(
	parameter int MAX_SIDE = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	lzrms_cell_if.sink     cells,
	lzrms_result_if.source result,
	lzrms_cfg_if.sink      cfg
);
	localparam int IW = $clog2(MAX_SIDE);

	logic [SIZE_W-1:0] matrix_size_q;
	logic              accept;
	logic              in_ready;
	logic [IW-1:0]     col;
	logic [IW-1:0]     anti_addr;
	pos_flags_t        flags;
	result_t           result_data;
	logic              out_valid;

	// The size register is always writable; the user must write it only while the block is idle (not enforced).
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_size_q <= SIZE_RESET;
		end else if (cfg.valid) begin
			matrix_size_q <= cfg.matrix_size;
		end
	end

	assign cells.ready = in_ready;
	assign accept = cells.valid && in_ready;

	// Position counters run on the input side so that the column stores can be read
	// the cycle the cell is taken.
	lzrms_pos #(.MAX_SIDE(MAX_SIDE)) u_pos (
		.clk(clk),
		.arst_n(arst_n),
		.matrix_size(matrix_size_q),
		.accept(accept),
		.col(col),
		.anti_addr(anti_addr),
		.flags(flags)
	);

	lzrms_core #(.MAX_SIDE(MAX_SIDE)) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.cell_zero(cells.cell_value == '0),
		.col(col),
		.anti_addr(anti_addr),
		.flags(flags),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(result.ready),
		.result(result_data)
	);

	assign result.valid = out_valid;
	assign result.row_run = result_data.row_run;
	assign result.col_run = result_data.col_run;
	assign result.diag_run = result_data.diag_run;
	assign result.anti_diag_run = result_data.anti_diag_run;
	assign result.longest_run = result_data.longest_run;
endmodule

### bench/longest_zero_run_matrix_scan_top_tb.sv
// Self-checking testbench for the longest-zero-run matrix scanner top level.
module longest_zero_run_matrix_scan_top_tb;
	import lzrms_pkg::*;

	localparam int MAX_SIDE = 128;
	// Cycles to let pass after the last cell transfer before the size register
	// may change, so that no cell is still inside the pipeline.
	localparam int SETTLE_CYCLES = 6;
	// Length of the deliberate receiver hold-off that backs the block up.
	localparam int HOLD_CYCLES = 300;
	// Cycles without any transfer on any channel before the run is abandoned.
	localparam int STUCK_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_CELLS = 850;

	// Entries of the stimulus feed: a cell, a size write, a request for the
	// receiver to hold off, or a pause until every awaited result has come.
	typedef enum logic [1:0] {
		ITEM_CELL,
		ITEM_SIZE,
		ITEM_HOLD,
		ITEM_DRAIN
	} feed_kind_t;

	typedef struct {
		feed_kind_t kind;
		logic [CELL_W-1:0] value;
		int gap;
	} feed_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lzrms_cell_if cell_ch ();
	lzrms_result_if result_ch ();
	lzrms_cfg_if cfg_ch ();

	longest_zero_run_matrix_scan_top #(
		.MAX_SIDE(MAX_SIDE)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cells(cell_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	always #5 clk = ~clk;

	// Stimulus feed, filled entirely before reset is released.
	feed_item_t scan_feed[$];

	// Results the predictor has worked out and that have not yet arrived.
	result_t awaited_runs[$];

	// Predictor state: our own image of the scanner.
	logic [SIZE_W-1:0] scan_size;
	int unsigned scan_row;
	int unsigned scan_col;
	run_t horiz_run;
	run_t diag_held;
	run_t vert_line[MAX_SIDE];
	run_t diag_line[MAX_SIDE];
	run_t anti_line[MAX_SIDE];
	run_t best[NUM_DIRS];

	// Handshake bookkeeping shared between the clocked processes.
	logic cell_taken = 1'b0;
	logic cfg_taken = 1'b0;
	int since_cell = 0;
	int stuck_cycles = 0;
	int mismatches = 0;
	int hold_orders = 0;

	// Generation-time tracking of the raster position, so that the feed knows
	// where each matrix ends.
	int unsigned gen_side = MAX_SIDE;
	int unsigned gen_row = 0;
	int unsigned gen_col = 0;
	int cells_queued = 0;
	logic calm = 1'b0;
	int calm_left = 0;

	task automatic note_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// Side length the block really uses for a register value.
	function automatic int unsigned side_of(input logic [SIZE_W-1:0] size);
		if (size == 0) begin
			return 1;
		end
		return (size > MAX_SIDE) ? MAX_SIDE : size;
	endfunction

	// Idle lengths: mostly none or short, now and then a long one.
	function automatic int draw_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			return 0;
		end else if (pick < 85) begin
			return $urandom_range(1, 3);
		end else if (pick < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CELL_W-1:0] draw_cell(input int zero_pct);
		if ($urandom_range(0, 99) < zero_pct) begin
			return '0;
		end
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'h0000_0001;
			default: return $urandom;
		endcase
	endfunction

	// A zero extends the run, saturating at the counter limit; anything else
	// breaks it.
	function automatic run_t grow_run(input logic is_zero, input run_t prev);
		if (!is_zero) begin
			return run_t'(0);
		end
		return (prev == 8'hff) ? prev : prev + run_t'(1);
	endfunction

	function automatic void keep_best(input int dir, input run_t run);
		if (run > best[dir]) begin
			best[dir] = run;
		end
	endfunction

	// Folds one accepted cell into the predictor and, at the end of a matrix,
	// queues the five run lengths that the block must report.
	task automatic scan_cell(input logic [CELL_W-1:0] value);
		int unsigned side;
		int unsigned r;
		int unsigned c;
		logic zero;
		logic first_row;
		logic first_col;
		logic last_col;
		logic last_row;
		run_t run;
		run_t above;
		result_t res;
		side = side_of(scan_size);
		r = scan_row;
		c = scan_col;
		zero = (value == '0);
		first_row = (r == 0);
		first_col = (c == 0);
		last_col = (c + 1 >= side) || (c + 1 >= MAX_SIDE);
		last_row = (r + 1 >= side);
		if (c >= MAX_SIDE) begin
			c = MAX_SIDE - 1;
		end

		run = grow_run(zero, first_col ? run_t'(0) : horiz_run);
		horiz_run = run;
		keep_best(DIR_ROW, run);

		run = grow_run(zero, first_row ? run_t'(0) : vert_line[c]);
		vert_line[c] = run;
		keep_best(DIR_COL, run);

		// The down-right predecessor sits one column to the left in the row
		// above; that entry has already been overwritten, so it is held over.
		above = first_row ? run_t'(0) : diag_line[c];
		run = grow_run(zero, (first_row || first_col) ? run_t'(0) : diag_held);
		diag_held = above;
		diag_line[c] = run;
		keep_best(DIR_DIAG, run);

		run = grow_run(zero, (first_row || last_col) ? run_t'(0) : anti_line[c + 1]);
		anti_line[c] = run;
		keep_best(DIR_ANTI, run);

		if (!last_col) begin
			scan_col = c + 1;
		end else begin
			scan_col = 0;
			if (!last_row) begin
				scan_row = r + 1;
			end else begin
				res.row_run = best[DIR_ROW];
				res.col_run = best[DIR_COL];
				res.diag_run = best[DIR_DIAG];
				res.anti_diag_run = best[DIR_ANTI];
				res.longest_run = '0;
				for (int k = 0; k < NUM_DIRS; k++) begin
					if (best[k] > res.longest_run) begin
						res.longest_run = best[k];
					end
				end
				awaited_runs.push_back(res);
				scan_row = 0;
				horiz_run = '0;
				diag_held = '0;
				for (int k = 0; k < NUM_DIRS; k++) begin
					best[k] = '0;
				end
			end
		end
	endtask

	task automatic compare_runs(input result_t seen, input result_t want);
		string names[5] = '{"row_run", "col_run", "diag_run", "anti_diag_run",
			"longest_run"};
		for (int k = 0; k < 5; k++) begin
			if (seen[8*(4-k) +: 8] !== want[8*(4-k) +: 8]) begin
				note_mismatch($sformatf("%s got %0d, expected %0d", names[k],
					seen[8*(4-k) +: 8], want[8*(4-k) +: 8]));
			end
		end
	endtask

	// Queues one cell and advances the generation-time raster position.
	task automatic queue_cell(input logic [CELL_W-1:0] value);
		feed_item_t item;
		if (calm_left == 0) begin
			calm = ($urandom_range(0, 3) == 0);
			calm_left = $urandom_range(20, 200);
		end
		calm_left--;
		item.kind = ITEM_CELL;
		item.value = value;
		item.gap = calm ? 0 : draw_gap();
		scan_feed.push_back(item);
		cells_queued++;
		if (gen_col + 1 >= gen_side) begin
			gen_col = 0;
			gen_row = (gen_row + 1 >= gen_side) ? 0 : gen_row + 1;
		end else begin
			gen_col++;
		end
	endtask

	task automatic queue_marker(input feed_kind_t kind, input logic [CELL_W-1:0] value);
		feed_item_t item;
		item.kind = kind;
		item.value = value;
		item.gap = 0;
		scan_feed.push_back(item);
		if (kind == ITEM_SIZE) begin
			gen_side = side_of(value[SIZE_W-1:0]);
		end
	endtask

	// Finishes the matrix in progress, or sends a whole one from its start.
	task automatic queue_to_matrix_end(input int zero_pct);
		do begin
			queue_cell(draw_cell(zero_pct));
		end while (gen_row != 0 || gen_col != 0);
	endtask

	// Monitor: samples every channel at the rising edge, feeds accepted cells
	// and size writes to the predictor and checks every result transfer.
	always @(posedge clk) begin
		result_t seen;
		logic moved;
		if (arst_n) begin
			moved = 1'b0;
			cell_taken <= cell_ch.valid && cell_ch.ready;
			cfg_taken <= cfg_ch.valid && cfg_ch.ready;
			if (cell_ch.valid && cell_ch.ready) begin
				scan_cell(cell_ch.cell_value);
				since_cell <= 0;
				moved = 1'b1;
			end else if (since_cell < SETTLE_CYCLES) begin
				since_cell <= since_cell + 1;
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				scan_size = cfg_ch.matrix_size;
				moved = 1'b1;
			end
			if (result_ch.valid && result_ch.ready) begin
				seen = {result_ch.row_run, result_ch.col_run, result_ch.diag_run,
					result_ch.anti_diag_run, result_ch.longest_run};
				if (awaited_runs.size() == 0) begin
					note_mismatch("result transfer with no result awaited");
				end else begin
					compare_runs(seen, awaited_runs.pop_front());
				end
				moved = 1'b1;
			end
			stuck_cycles <= moved ? 0 : stuck_cycles + 1;
		end
	end

	// Driver: works through the feed at the falling edge. Cells are offered
	// with their planned gaps; a size write waits until the block is idle.
	always @(negedge clk) begin
		logic cell_v;
		logic size_v;
		int idle_left;
		cell_v = cell_ch.valid;
		size_v = cfg_ch.valid;
		if (arst_n) begin
			if (cell_taken) begin
				cell_v = 1'b0;
			end
			if (cfg_taken) begin
				size_v = 1'b0;
			end
			if (!cell_v && !size_v && scan_feed.size() != 0) begin
				if (idle_left > 0) begin
					idle_left--;
				end else begin
					case (scan_feed[0].kind)
						ITEM_CELL: begin
							cell_v = 1'b1;
							cell_ch.cell_value <= scan_feed[0].value;
							idle_left = scan_feed[0].gap;
							scan_feed.delete(0);
						end
						ITEM_SIZE: begin
							// Idle means every awaited result is in and the last cell
							// has had time to leave the pipeline.
							if (since_cell >= SETTLE_CYCLES && awaited_runs.size() == 0) begin
								size_v = 1'b1;
								cfg_ch.matrix_size <= scan_feed[0].value[SIZE_W-1:0];
								scan_feed.delete(0);
							end
						end
						ITEM_HOLD: begin
							hold_orders <= hold_orders + 1;
							scan_feed.delete(0);
						end
						ITEM_DRAIN: begin
							if (awaited_runs.size() == 0) begin
								scan_feed.delete(0);
							end
						end
					endcase
				end
			end
			cell_ch.valid <= cell_v;
			cfg_ch.valid <= size_v;
		end
	end

	// Receiver: drives ready at the falling edge. It alternates between calm
	// stretches and choppy ones, and on request holds off for a long stretch
	// that it counts itself.
	always @(negedge clk) begin
		logic take;
		int holds_served;
		int hold_left;
		int stall_left;
		int mood_left;
		logic choppy;
		if (arst_n) begin
			take = 1'b1;
			if (mood_left == 0) begin
				choppy = ($urandom_range(0, 2) != 0);
				mood_left = $urandom_range(50, 400);
			end
			mood_left--;
			if (holds_served != hold_orders) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				take = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				take = 1'b0;
			end else if (choppy && $urandom_range(0, 99) < 25) begin
				stall_left = draw_gap();
				take = 1'b0;
			end
			result_ch.ready <= take;
		end
	end

	initial begin
		int pick;
		int side_req;
		int pct;
		int count;
		int base;
		logic timed_out;

		cell_ch.valid = 1'b0;
		cell_ch.cell_value = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.matrix_size = '0;
		result_ch.ready = 1'b0;

		scan_size = SIZE_RESET;
		scan_row = 0;
		scan_col = 0;
		horiz_run = '0;
		diag_held = '0;
		for (int k = 0; k < MAX_SIDE; k++) begin
			vert_line[k] = '0;
			diag_line[k] = '0;
			anti_line[k] = '0;
		end
		for (int k = 0; k < NUM_DIRS; k++) begin
			best[k] = '0;
		end

		// Three zeros at the reset side, then a shrink to two in the middle of
		// row 0: the row ends at once and a second row finishes the matrix.
		// Shrinking only ever reads line entries written earlier in the matrix.
		repeat (3) queue_cell('0);
		queue_marker(ITEM_SIZE, 32'd2);
		queue_cell('0);
		queue_cell('0);
		queue_cell(32'h8000_0000);

		// A size of zero behaves as one: every cell is a matrix of its own.
		queue_marker(ITEM_SIZE, 32'd0);
		queue_cell('0);
		queue_cell(32'h7fff_ffff);
		queue_cell(32'h8000_0000);
		queue_cell(32'hffff_ffff);
		queue_cell(32'h0000_0001);
		queue_marker(ITEM_SIZE, 32'd1);
		queue_cell('0);

		// A 3x3 cross of zeros gives full-length runs on both diagonals.
		queue_marker(ITEM_SIZE, 32'd3);
		for (int k = 0; k < 9; k++) begin
			queue_cell((k % 2 == 0) ? 32'd0 : 32'd5);
		end
		queue_marker(ITEM_SIZE, 32'd2);
		repeat (4) queue_cell('0);

		// Back-pressure: one-cell matrices sent without gaps while the receiver
		// holds off, so results pile up and the cell channel stalls; then the
		// sender waits until every result has been taken.
		queue_marker(ITEM_SIZE, 32'd1);
		queue_marker(ITEM_HOLD, '0);
		calm = 1'b1;
		calm_left = 45;
		repeat (40) queue_cell(draw_cell(50));
		queue_marker(ITEM_DRAIN, '0);

		// Two rows at the largest side, the second one all zero. Between them the
		// side is rewritten as 255, which also means 128. A shrink to three then
		// ends the matrix with a short third row. Afterwards every line entry has
		// been written, so later size changes in the middle of a matrix may grow
		// it as well.
		queue_marker(ITEM_SIZE, 32'd128);
		repeat (MAX_SIDE) queue_cell(draw_cell(97));
		queue_marker(ITEM_SIZE, 32'd255);
		repeat (MAX_SIDE) queue_cell('0);
		queue_marker(ITEM_SIZE, 32'd3);
		queue_to_matrix_end(97);

		// Random part: mostly small matrices of random density, now and then a
		// partial matrix followed by a size change in its middle.
		base = cells_queued;
		while (cells_queued - base < RANDOM_CELLS) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				side_req = $urandom_range(1, 6);
			end else if (pick < 80) begin
				side_req = $urandom_range(7, 16);
			end else if (pick < 94) begin
				side_req = $urandom_range(17, 40);
			end else begin
				side_req = 0;
			end
			queue_marker(ITEM_SIZE, side_req);
			case ($urandom_range(0, 3))
				0: pct = 5;
				1: pct = 40;
				2: pct = 75;
				default: pct = 95;
			endcase
			if ($urandom_range(0, 99) < 15) begin
				count = $urandom_range(1, gen_side * gen_side);
				repeat (count) queue_cell(draw_cell(pct));
			end else begin
				queue_to_matrix_end(pct);
			end
			if ($urandom_range(0, 99) < 4) begin
				queue_marker(ITEM_DRAIN, '0);
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Run until the feed is used up and every awaited result is in, unless
		// the watchdog sees the channels stuck for too long. The check is made at
		// the rising edge, where the driver's last update has settled.
		while ((scan_feed.size() != 0 || cell_ch.valid || cfg_ch.valid
				|| awaited_runs.size() != 0) && stuck_cycles < STUCK_LIMIT) begin
			@(posedge clk);
		end
		timed_out = (stuck_cycles >= STUCK_LIMIT);
		if (timed_out) begin
			$display("timeout at %0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
		end else begin
			// Any stray result after the last one would show up here.
			repeat (DRAIN_CYCLES) @(negedge clk);
		end
		if (awaited_runs.size() != 0) begin
			note_mismatch($sformatf("%0d results never arrived", awaited_runs.size()));
		end

		if (mismatches == 0 && !timed_out) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### longest_zero_run_matrix_scan_top.f
rtl/core/lzrms_pkg.sv
rtl/core/lzrms_ifs.sv
rtl/core/lzrms_ram.sv
rtl/core/lzrms_pos.sv
rtl/core/lzrms_core.sv
rtl/core/longest_zero_run_matrix_scan_top.sv
bench/longest_zero_run_matrix_scan_top_tb.sv
